// ===== src/byte_stream_tokenizer_defines.svh =====
// assertion macros shared by the tokenizer checkers
`ifndef BYTE_STREAM_TOKENIZER_DEFINES_SVH
`define BYTE_STREAM_TOKENIZER_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define BST_ASSERT_IMPL(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// next-cycle implication, disabled while in reset
`define BST_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

// ===== src/bst_pkg.sv =====
// types, constants and reset values shared by the tokenizer modules
package bst_pkg;

  localparam int ROW_BITS = 20;
  localparam int COL_BITS = 16;
  localparam int LEN_BITS = 16;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W = $clog2(FIFO_DEPTH);
  localparam int CNT_W = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_MINUS = 8'h2D;

  typedef enum logic [4:0] {
    K_INVALID, K_IDENT, K_NUMBER, K_STRING, K_NEWLINE,
    K_SPACE, K_TAB, K_LSPACE, K_LTAB,
    K_DOLLAR, K_LPAREN, K_RPAREN, K_STAR, K_DOT, K_LBRACE, K_RBRACE, K_SEMI,
    K_ASSIGN, K_COLON, K_SLASH, K_PLUS, K_MINUS, K_EQEQ, K_EQ, K_AT, K_BANG,
    K_LE, K_LT, K_GE, K_GT, K_ARROW
  } kind_e;

  typedef enum logic [3:0] {
    PEND_NONE   = 4'd0,
    PEND_IDENT  = 4'd1,
    PEND_NUMBER = 4'd2,
    PEND_STRING = 4'd3,
    PEND_SPACE  = 4'd5,
    PEND_TAB    = 4'd6,
    PEND_LSPACE = 4'd7,
    PEND_LTAB   = 4'd8,
    PEND_OP     = 4'd9
  } pend_e;

  typedef enum logic [2:0] {
    OPC_COLON, OPC_EQ, OPC_LT, OPC_GT, OPC_MINUS
  } opch_e;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_word_t;

  typedef struct packed {
    logic [4:0]          token_kind;
    logic [ROW_BITS-1:0] start_row;
    logic [COL_BITS-1:0] start_col;
    logic [LEN_BITS-1:0] token_length;
    logic                run_last;
    logic                stream_end;
  } out_word_t;

  typedef struct packed {
    pend_e               pend;
    opch_e               first;
    logic                frac;
    logic [ROW_BITS-1:0] tok_row;
    logic [COL_BITS-1:0] tok_col;
    logic [LEN_BITS-1:0] tok_len;
    logic [ROW_BITS-1:0] cur_row;
    logic [COL_BITS-1:0] cur_col;
    logic                prev_lf;
  } scan_state_t;

  // up to two words from one byte, in order
  typedef struct packed {
    logic [1:0] count;
    out_word_t  tok0;
    out_word_t  tok1;
  } scan_result_t;

  localparam scan_state_t STATE_RESET = '{
    pend:    PEND_NONE,
    first:   OPC_COLON,
    frac:    1'b0,
    tok_row: ROW_BITS'(1),
    tok_col: '0,
    tok_len: '0,
    cur_row: ROW_BITS'(1),
    cur_col: '0,
    prev_lf: 1'b0
  };

endpackage

// ===== src/bst_scan.sv =====
// per-byte scanner: next state and the words one byte produces
module bst_scan (
  input  bst_pkg::scan_state_t  state_i,
  input  bst_pkg::in_word_t     in_word_i,
  output bst_pkg::scan_state_t  state_o,
  output bst_pkg::scan_result_t result_o
);
  import bst_pkg::*;

  function automatic logic [ROW_BITS-1:0] sat_row(logic [ROW_BITS-1:0] v);
    return (v == '1) ? v : v + ROW_BITS'(1);
  endfunction

  function automatic logic [COL_BITS-1:0] sat_col(logic [COL_BITS-1:0] v);
    return (v == '1) ? v : v + COL_BITS'(1);
  endfunction

  function automatic logic [LEN_BITS-1:0] sat_len(logic [LEN_BITS-1:0] v);
    return (v == '1) ? v : v + LEN_BITS'(1);
  endfunction

  function automatic logic is_alpha(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB;
  endfunction

  function automatic kind_e single_op(logic [7:0] c);
    kind_e k;
    unique case (c)
      "$":     k = K_DOLLAR;
      "(":     k = K_LPAREN;
      ")":     k = K_RPAREN;
      "*":     k = K_STAR;
      ".":     k = K_DOT;
      "{":     k = K_LBRACE;
      "}":     k = K_RBRACE;
      ";":     k = K_SEMI;
      "/":     k = K_SLASH;
      "+":     k = K_PLUS;
      "@":     k = K_AT;
      "!":     k = K_BANG;
      default: k = K_INVALID;
    endcase
    return k;
  endfunction

  function automatic kind_e op_alone(opch_e f);
    kind_e k;
    unique case (f)
      OPC_COLON: k = K_COLON;
      OPC_EQ:    k = K_EQ;
      OPC_LT:    k = K_LT;
      OPC_GT:    k = K_GT;
      OPC_MINUS: k = K_MINUS;
      default:   k = K_COLON;
    endcase
    return k;
  endfunction

  function automatic kind_e op_pair(opch_e f);
    kind_e k;
    unique case (f)
      OPC_COLON: k = K_ASSIGN;
      OPC_EQ:    k = K_EQEQ;
      OPC_LT:    k = K_LE;
      OPC_GT:    k = K_GE;
      OPC_MINUS: k = K_ARROW;
      default:   k = K_ASSIGN;
    endcase
    return k;
  endfunction

  function automatic logic [7:0] op_second(opch_e f);
    return (f == OPC_MINUS) ? CH_GT : CH_EQ;
  endfunction

  function automatic out_word_t mk(kind_e k, logic [ROW_BITS-1:0] row,
                                   logic [COL_BITS-1:0] col, logic [LEN_BITS-1:0] len);
    out_word_t w;
    w.token_kind   = k;
    w.start_row    = row;
    w.start_col    = col;
    w.token_length = len;
    w.run_last     = 1'b0;
    w.stream_end   = 1'b0;
    return w;
  endfunction

  function automatic out_word_t pend_word(scan_state_t s);
    kind_e k;
    unique case (s.pend)
      PEND_IDENT:  k = K_IDENT;
      PEND_NUMBER: k = K_NUMBER;
      PEND_STRING: k = K_STRING;
      PEND_SPACE:  k = K_SPACE;
      PEND_TAB:    k = K_TAB;
      PEND_LSPACE: k = K_LSPACE;
      PEND_LTAB:   k = K_LTAB;
      PEND_OP:     k = op_alone(s.first);
      default:     k = K_INVALID;
    endcase
    return mk(k, s.tok_row, s.tok_col, s.tok_len);
  endfunction

  scan_state_t s;
  logic [7:0]  c;
  logic        last;
  logic        taken;
  logic        a_v, b_v, c_v;
  out_word_t   a_w, b_w, c_w;
  logic        start_v;
  pend_e       start_cls;
  opch_e       start_first;
  logic [1:0]  n;
  out_word_t   slot [2];

  always_comb begin
    s           = state_i;
    c           = in_word_i.text_byte;
    last        = in_word_i.final_byte;
    taken       = 1'b0;
    a_v         = 1'b0;
    b_v         = 1'b0;
    c_v         = 1'b0;
    a_w         = '0;
    b_w         = '0;
    c_w         = '0;
    start_v     = 1'b0;
    start_cls   = PEND_NONE;
    start_first = OPC_COLON;

    // does the byte continue what is pending
    unique case (s.pend)
      PEND_IDENT: begin
        taken = is_alpha(c) || is_digit(c) || c == "_";
      end
      PEND_NUMBER: begin
        if (is_digit(c)) begin
          taken = 1'b1;
        end else if (c == CH_DOT && !s.frac) begin
          taken  = 1'b1;
          s.frac = 1'b1;
        end
      end
      PEND_STRING: begin
        taken     = 1'b1;
        s.tok_len = sat_len(s.tok_len);
        if (c == CH_QUOTE || c == CH_LF) begin
          a_v    = 1'b1;
          a_w    = pend_word(s);
          s.pend = PEND_NONE;
        end
      end
      PEND_SPACE, PEND_TAB, PEND_LSPACE, PEND_LTAB: begin
        taken = is_blank(c);
      end
      PEND_OP: begin
        if (c == op_second(s.first)) begin
          a_v    = 1'b1;
          a_w    = mk(op_pair(s.first), s.tok_row, s.tok_col, LEN_BITS'(2));
          s.pend = PEND_NONE;
          taken  = 1'b1;
        end
      end
      default: ;
    endcase

    if (taken) begin
      if (s.pend != PEND_NONE && s.pend != PEND_STRING) begin
        s.tok_len = sat_len(s.tok_len);
      end
    end else begin
      if (s.pend != PEND_NONE) begin
        a_v    = 1'b1;
        a_w    = pend_word(s);
        s.pend = PEND_NONE;
      end
      if (c == CH_LF || c == CH_CR) begin
        b_v = 1'b1;
        b_w = mk(K_NEWLINE, s.cur_row, s.cur_col, LEN_BITS'(1));
      end else if (is_blank(c)) begin
        start_v = 1'b1;
        if (c == CH_TAB) begin
          start_cls = s.prev_lf ? PEND_LTAB : PEND_TAB;
        end else begin
          start_cls = s.prev_lf ? PEND_LSPACE : PEND_SPACE;
        end
      end else if (is_alpha(c) || c == "_") begin
        start_v   = 1'b1;
        start_cls = PEND_IDENT;
      end else if (c == CH_QUOTE) begin
        start_v   = 1'b1;
        start_cls = PEND_STRING;
      end else if (is_digit(c)) begin
        start_v   = 1'b1;
        start_cls = PEND_NUMBER;
      end else if (c == CH_COLON || c == CH_EQ || c == CH_LT || c == CH_GT
                   || c == CH_MINUS) begin
        start_v   = 1'b1;
        start_cls = PEND_OP;
        priority if (c == CH_COLON) begin
          start_first = OPC_COLON;
        end else if (c == CH_EQ) begin
          start_first = OPC_EQ;
        end else if (c == CH_LT) begin
          start_first = OPC_LT;
        end else if (c == CH_GT) begin
          start_first = OPC_GT;
        end else begin
          start_first = OPC_MINUS;
        end
      end else begin
        b_v = 1'b1;
        b_w = mk(single_op(c), s.cur_row, s.cur_col, LEN_BITS'(1));
      end
    end

    if (start_v) begin
      s.pend    = start_cls;
      s.tok_row = s.cur_row;
      s.tok_col = s.cur_col;
      s.tok_len = LEN_BITS'(1);
      s.frac    = 1'b0;
      if (start_cls == PEND_OP) begin
        s.first = start_first;
      end
    end

    // position of the next byte
    if (c == CH_LF) begin
      s.cur_row = sat_row(s.cur_row);
      s.cur_col = '0;
    end else begin
      s.cur_col = sat_col(s.cur_col);
    end
    s.prev_lf = (c == CH_LF);

    // end of text flushes and starts over
    if (last) begin
      if (s.pend != PEND_NONE) begin
        c_v = 1'b1;
        c_w = pend_word(s);
      end
      s = STATE_RESET;
    end

    // pack in order; never more than two
    n       = 2'd0;
    slot[0] = '0;
    slot[1] = '0;
    if (a_v) begin
      slot[0] = a_w;
      n       = 2'd1;
    end
    if (b_v) begin
      slot[n[0]] = b_w;
      n          = n + 2'd1;
    end
    if (c_v) begin
      slot[n[0]] = c_w;
      n          = n + 2'd1;
    end
    if (n != 2'd0) begin
      slot[n[1]].run_last   = 1'b1;
      slot[n[1]].stream_end = last;
    end
  end

  assign state_o         = s;
  assign result_o.count  = n;
  assign result_o.tok0   = slot[0];
  assign result_o.tok1   = slot[1];

endmodule

// ===== src/bst_fifo.sv =====
// small output queue taking up to two words per cycle
module bst_fifo (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_en_i,
  input  bst_pkg::scan_result_t push_i,
  input  logic                  pop_i,
  output bst_pkg::out_word_t    head_o,
  output logic                  valid_o,
  output logic                  full_o
);
  import bst_pkg::*;

  out_word_t          mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_q, wr_d;
  logic [PTR_W-1:0]   rd_q, rd_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d;
  logic [1:0]         n_push;

  assign n_push  = push_en_i ? push_i.count : 2'd0;
  assign valid_o = (cnt_q != '0);
  assign head_o  = mem_q[rd_q];
  // room for two more words is needed to take a byte
  assign full_o  = (cnt_q > CNT_W'(FIFO_DEPTH - 2));

  always_comb begin
    wr_d  = wr_q + PTR_W'(n_push);
    rd_d  = (pop_i && valid_o) ? rd_q + PTR_W'(1) : rd_q;
    cnt_d = cnt_q + CNT_W'(n_push) - CNT_W'(pop_i && valid_o);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_q] <= push_i.tok0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_q + PTR_W'(1)] <= push_i.tok1;
    end
  end

endmodule

// ===== src/byte_stream_tokenizer.sv =====
// byte stream tokenizer: cuts text, one byte per word, into token words
// the tokens a byte causes are written into the output queue when the byte is taken
// throughput: 1 byte per cycle; input stalls only while the 4-entry output queue
//   holds 3 or more words, which happens when bytes yield two tokens faster than
//   they are drained
// reset: async active low; scan state back to row 1 column 0, output queue empty
module byte_stream_tokenizer (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bst_pkg::in_word_t in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bst_pkg::out_word_t out_word_o
);
  import bst_pkg::*;

  // scan state: pending token, its start position and length, next byte position
  scan_state_t  state_q, state_d;
  scan_result_t result;
  logic         in_take;
  logic         out_take;
  logic         queue_full;

  // a byte goes in whenever the queue can take both words it might produce
  assign in_stall_o = queue_full;
  assign in_take    = in_valid_i && !in_stall_o;
  assign out_take   = out_valid_o && !out_stall_i;

  // single pass over the byte: classify, close the pending token, open a new one
  bst_scan u_scan (
    .state_i   (state_q),
    .in_word_i (in_word_i),
    .state_o   (state_d),
    .result_o  (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else if (in_take) begin
      state_q <= state_d;
    end
  end

  // result side: queue keeps the input moving while the consumer stalls
  bst_fifo u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_en_i (in_take),
    .push_i    (result),
    .pop_i     (out_take),
    .head_o    (out_word_o),
    .valid_o   (out_valid_o),
    .full_o    (queue_full)
  );

endmodule

// ===== src/bst_checker.sv =====
// port-level checks for the tokenizer, bound to the top level
`include "byte_stream_tokenizer_defines.svh"

module bst_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input bst_pkg::in_word_t  in_word_i,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input bst_pkg::out_word_t out_word_o
);
  import bst_pkg::*;

  `BST_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_word_o), "stalled output word changed")
  `BST_ASSERT_NEXT(a_final_yields, in_valid_i && !in_stall_o && in_word_i.final_byte, out_valid_o, "final byte gave no token")
  `BST_ASSERT_IMPL(a_end_is_last, out_valid_o && out_word_o.stream_end, out_word_o.run_last, "stream end without run last")
  `BST_ASSERT_IMPL(a_stall_backlog, in_stall_o, out_valid_o, "input stalled with empty output queue")

endmodule

bind byte_stream_tokenizer bst_checker u_bst_checker (.*);
